### hdl/dwa_pkg.sv
package dwa_pkg;

	localparam int NUM_STATES  = 16;
	localparam int SYMBOL_BITS = 8;
	localparam int SYM_COUNT   = 1 << SYMBOL_BITS;
	localparam int TBL_DEPTH   = NUM_STATES * SYM_COUNT;
	localparam int TBL_ADDR_W  = $clog2(TBL_DEPTH);

	localparam int STATE_W = 4;
	localparam int SYM_W   = 8;
	localparam int REQ_W   = 2;
	localparam int ENTRY_W = STATE_W + 1;

	localparam int APB_ADDR_W = 3;

	localparam int FIFO_DEPTH = 3;
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SYMBOL = 2'd1;
	localparam logic [REQ_W-1:0] REQ_END    = 2'd2;

	localparam logic REG_START = 1'b0;
	localparam logic REG_FINAL = 1'b1;

	typedef struct packed {
		logic               accepted;
		logic               empty_word;
		logic               missing_transition;
		logic [STATE_W-1:0] end_state;
	} result_t;

	typedef logic [TBL_ADDR_W-1:0] tbl_addr_t;

	function automatic logic state_ok(input logic [STATE_W-1:0] st);
		return int'(st) < NUM_STATES;
	endfunction

	function automatic logic sym_ok(input logic [SYM_W-1:0] sym);
		return (int'(sym) >> SYMBOL_BITS) == 0;
	endfunction

	function automatic tbl_addr_t tbl_addr(input logic [STATE_W-1:0] st,
			input logic [SYM_W-1:0] sym);
		return TBL_ADDR_W'((int'(st) << SYMBOL_BITS) + (int'(sym) & (SYM_COUNT - 1)));
	endfunction

endpackage

### hdl/dfa_word_acceptor.sv
// Table-driven word acceptor. Each request on the slave stream is a transition load, a word
// symbol or an end of word, and the block takes one request per clock cycle, with symbols of
// the same word back to back: the transition memory is read once per symbol, and the target
// state returned by that read directly forms the address of the next symbol's read. A load
// that hits an entry already holding a transition leaves it unchanged. Only an end of word
// produces a result on the master stream; a three-entry result queue lets requests keep
// flowing while results wait to be taken, until it has no room left. After reset the
// transition memory is swept clear, one entry per cycle, and no request is taken until all
// 4096 entries (the table depth) are cleared; register writes are accepted throughout.
module dfa_word_acceptor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dwa_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// from_state [3:0], symbol [11:4], to_state [15:12]
	input  logic [15:0]                     s_tdata,
	// req_type [1:0]
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// accepted [0], empty_word [1], missing_transition [2], end_state [6:3], zero [7]
	output logic [7:0]                      m_tdata
);
	import dwa_pkg::*;

	logic [STATE_W-1:0] start_state;
	logic [15:0]        final_mask;

	logic [REQ_W-1:0]   in_req;
	logic [STATE_W-1:0] in_from;
	logic [SYM_W-1:0]   in_sym;
	logic [STATE_W-1:0] in_to;
	logic               in_acc;

	logic [TBL_ADDR_W:0] clr_q;
	logic                clr_busy;

	logic               valid_s1;
	logic [REQ_W-1:0]   req_s1;
	tbl_addr_t          addr_s1;
	logic               ok_s1;
	logic [STATE_W-1:0] to_s1;

	logic [STATE_W-1:0] cur_q;
	logic               dead_q;
	logic               seen_q;
	logic [STATE_W-1:0] nxt_cur;
	logic               nxt_dead;
	logic               nxt_seen;

	logic               fwd_v_q;
	tbl_addr_t          fwd_addr_q;
	logic [ENTRY_W-1:0] fwd_data_q;

	logic [ENTRY_W-1:0] ram_rdata;
	logic [ENTRY_W-1:0] entry;
	logic [STATE_W-1:0] src_s1;
	logic               load_we;

	logic               ram_we;
	tbl_addr_t          ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [STATE_W-1:0] src_s0;
	tbl_addr_t          addr_s0;
	logic               ok_s0;

	logic                  res_push;
	result_t               res;
	result_t               head;
	logic [FIFO_CNT_W-1:0] fifo_cnt;
	logic                  end_pending;

	dwa_regs u_regs (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.start_state      (start_state),
		.final_state_mask (final_mask)
	);

	assign in_req  = s_tuser;
	assign in_from = s_tdata[3:0];
	assign in_sym  = s_tdata[11:4];
	assign in_to   = s_tdata[15:12];

	assign clr_busy    = clr_q != (TBL_ADDR_W + 1)'(TBL_DEPTH);
	assign end_pending = valid_s1 && (req_s1 == REQ_END);
	assign s_tready    = !clr_busy
		&& ((int'(fifo_cnt) + int'(end_pending)) < FIFO_DEPTH);
	assign in_acc      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clr_busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// A load written in the previous cycle is not yet visible in the read data.
	assign entry = (fwd_v_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : ram_rdata;
	assign src_s1 = seen_q ? cur_q : start_state;
	assign load_we = valid_s1 && (req_s1 == REQ_LOAD) && ok_s1 && !entry[STATE_W];

	always_comb begin
		nxt_cur  = cur_q;
		nxt_dead = dead_q;
		nxt_seen = seen_q;
		res_push = 1'b0;
		res      = '0;
		if (valid_s1) begin
			case (req_s1)
				REQ_SYMBOL: begin
					nxt_seen = 1'b1;
					if (dead_q) begin
						nxt_cur = src_s1;
					end else if (ok_s1 && state_ok(src_s1) && entry[STATE_W]) begin
						nxt_cur = entry[STATE_W-1:0];
					end else begin
						nxt_cur  = src_s1;
						nxt_dead = 1'b1;
					end
				end
				REQ_END: begin
					res_push               = 1'b1;
					res.empty_word         = !seen_q;
					res.missing_transition = seen_q && dead_q;
					res.accepted           = seen_q && !dead_q && state_ok(src_s1)
						&& final_mask[src_s1];
					res.end_state          = (seen_q && dead_q) ? '0 : src_s1;
					nxt_cur  = start_state;
					nxt_dead = 1'b0;
					nxt_seen = 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign src_s0  = nxt_seen ? nxt_cur : start_state;
	assign addr_s0 = (in_req == REQ_SYMBOL) ? tbl_addr(src_s0, in_sym)
		: tbl_addr(in_from, in_sym);
	assign ok_s0   = (in_req == REQ_SYMBOL) ? sym_ok(in_sym)
		: (sym_ok(in_sym) && state_ok(in_from) && state_ok(in_to));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cur_q    <= '0;
			dead_q   <= 1'b0;
			seen_q   <= 1'b0;
			fwd_v_q  <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
			cur_q    <= nxt_cur;
			dead_q   <= nxt_dead;
			seen_q   <= nxt_seen;
			fwd_v_q  <= load_we;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1  <= in_req;
			addr_s1 <= addr_s0;
			ok_s1   <= ok_s0;
			to_s1   <= in_to;
		end
		fwd_addr_q <= addr_s1;
		fwd_data_q <= {1'b1, to_s1};
	end

	assign ram_we    = clr_busy || load_we;
	assign ram_waddr = clr_busy ? clr_q[TBL_ADDR_W-1:0] : addr_s1;
	assign ram_wdata = clr_busy ? '0 : {1'b1, to_s1};

	dwa_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TBL_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_s0),
		.rdata (ram_rdata)
	);

	dwa_rslt_fifo u_rslt (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_push),
		.push_data  (res),
		.pop        (m_tready),
		.head_valid (m_tvalid),
		.head_data  (head),
		.count      (fifo_cnt)
	);

	assign m_tdata = {1'b0, head.end_state, head.missing_transition, head.empty_word,
		head.accepted};

endmodule

### hdl/dwa_ram.sv
module dwa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/dwa_regs.sv
module dwa_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dwa_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output logic [dwa_pkg::STATE_W-1:0]     start_state,
	output logic [15:0]                     final_state_mask
);
	import dwa_pkg::*;

	logic [STATE_W-1:0] start_q;
	logic [15:0]        final_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			final_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_START: start_q <= pwdata[STATE_W-1:0];
				REG_FINAL: final_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_START: prdata = {{(32 - STATE_W){1'b0}}, start_q};
			REG_FINAL: prdata = {16'b0, final_q};
			default:   prdata = '0;
		endcase
	end

	assign start_state      = start_q;
	assign final_state_mask = final_q;

endmodule

### hdl/dwa_rslt_fifo.sv
module dwa_rslt_fifo (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  dwa_pkg::result_t                 push_data,
	input  logic                             pop,
	output logic                             head_valid,
	output dwa_pkg::result_t                 head_data,
	output logic [dwa_pkg::FIFO_CNT_W-1:0]   count
);
	import dwa_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	result_t                entry_q [FIFO_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [FIFO_CNT_W-1:0]  cnt_q;
	logic                   do_pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (int'(p) == FIFO_DEPTH - 1) ? '0 : p + 1'b1;
	endfunction

	assign head_valid = cnt_q != '0;
	assign head_data  = entry_q[rd_ptr_q];
	assign count      = cnt_q;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
